/* src/pcc_pkg.sv */
package pcc_pkg;

  localparam int DEF_MAX_CODE_BITS = 16;
  localparam int DEF_MAX_CODES     = 256;

  localparam int STATUS_W = 3;

  localparam logic [STATUS_W-1:0] ST_OK             = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EARLIER_PREFIX = 3'd1;
  localparam logic [STATUS_W-1:0] ST_THIS_PREFIX    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL           = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FAILED         = 3'd5;

  // Control half of the word that walks down the cell chain.
  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic                stored;
    logic                last;
  } pcc_tok_t;

endpackage

/* src/pcc_if.sv */
interface pcc_in_if #(
  parameter int W  = 16,
  parameter int LW = 5
);
  logic          valid;
  logic          ready;
  logic          start_req;
  logic [W-1:0]  code_bits;
  logic [LW-1:0] code_length;
  logic          last_code;

  modport source (output valid, start_req, code_bits, code_length, last_code, input ready);
  modport sink   (input valid, start_req, code_bits, code_length, last_code, output ready);
endinterface

interface pcc_out_if;
  logic       valid;
  logic       ready;
  logic       still_valid;
  logic [2:0] status;
  logic       set_done;

  modport source (output valid, still_valid, status, set_done, input ready);
  modport sink   (input valid, still_valid, status, set_done, output ready);
endinterface

/* src/pcc_cell.sv */
module pcc_cell import pcc_pkg::*; #(
  parameter int W  = DEF_MAX_CODE_BITS,
  parameter int LW = $clog2(DEF_MAX_CODE_BITS + 1),
  parameter int CW = $clog2(DEF_MAX_CODES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  pcc_tok_t      tok_i,
  input  logic [W-1:0]  word_i,
  input  logic [LW-1:0] len_i,
  input  logic [CW-1:0] rem_i,
  output pcc_tok_t      tok_o,
  output logic [W-1:0]  word_o,
  output logic [LW-1:0] len_o,
  output logic [CW-1:0] rem_o
);

  pcc_tok_t            tok_r, tok_nxt;
  logic [W-1:0]        word_r;
  logic [LW-1:0]       len_r;
  logic [CW-1:0]       rem_r, rem_nxt;
  logic [W-1:0]        code_r;
  logic [LW-1:0]       slen_r;

  logic [LW-1:0]       shorter;
  logic [W-1:0]        mask;
  logic                hit;
  logic                live;
  logic                slot;
  logic [STATUS_W-1:0] cmp_status;

  // Words are held left-justified, so a prefix test looks at the top bits only.
  always_comb begin
    shorter = (len_i < slen_r) ? len_i : slen_r;
    mask    = ~({W{1'b1}} >> shorter);
    hit     = ((word_i ^ code_r) & mask) == '0;
    if (len_i == slen_r) begin
      cmp_status = ST_DUPLICATE;
    end else if (slen_r < len_i) begin
      cmp_status = ST_EARLIER_PREFIX;
    end else begin
      cmp_status = ST_THIS_PREFIX;
    end
  end

  // The remaining count reaches zero at the first empty cell, which takes the word.
  always_comb begin
    live    = tok_i.valid && (tok_i.status == ST_OK) && !tok_i.stored;
    slot    = live && (rem_i == '0);
    tok_nxt = tok_i;
    if (slot) begin
      tok_nxt.stored = 1'b1;
    end else if (live && hit) begin
      tok_nxt.status = cmp_status;
    end
    rem_nxt = (rem_i == '0) ? '0 : rem_i - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_i;
    len_r  <= len_i;
    rem_r  <= rem_nxt;
    if (slot) begin
      code_r <= word_i;
      slen_r <= len_i;
    end
  end

  assign tok_o  = tok_r;
  assign word_o = word_r;
  assign len_o  = len_r;
  assign rem_o  = rem_r;

endmodule

/* src/prefix_code_checker.sv */
// Prefix-free code checker. Each code word on the input channel is compared
// against every word stored since the last start_req, and one result is
// returned per word. The store is a chain of MAX_CODES cells, each holding one
// word; an incoming word walks one cell per clock to the end of the chain,
// and the next word is taken once the previous result has moved into the
// output register. The output register plus a one-entry hold stage let a
// new word enter while a result still waits. Words are masked to
// code_length bits and lengths above MAX_CODE_BITS are clipped. Once a set
// fails it stays failed until the next start_req. No clearing pass follows
// reset.
module prefix_code_checker import pcc_pkg::*; #(
  parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS,
  parameter int MAX_CODES     = DEF_MAX_CODES
) (
  input  logic       clk,
  input  logic       rst_n,
  pcc_in_if.sink     in_ch,
  pcc_out_if.source  out_ch
);

  localparam int W  = MAX_CODE_BITS;
  localparam int LW = $clog2(MAX_CODE_BITS + 1);
  localparam int CW = $clog2(MAX_CODES + 1);
  localparam int N  = MAX_CODES;

  pcc_tok_t      tok_c  [0:N];
  logic [W-1:0]  word_c [0:N];
  logic [LW-1:0] len_c  [0:N];
  logic [CW-1:0] rem_c  [0:N];
  logic [N:0]    tok_valid_vec;

  logic [CW-1:0]       count_r;
  logic                failed_r;
  logic                busy_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_done_r;
  logic                pend_valid_r;
  logic [STATUS_W-1:0] pend_status_r;
  logic                pend_done_r;

  logic                in_acc;
  logic                failed_eff;
  logic [LW-1:0]       len_sat;
  logic [LW-1:0]       shamt;
  logic [STATUS_W-1:0] end_status;
  logic                out_free;

  assign in_ch.ready = !busy_r;
  assign in_acc      = in_ch.valid && !busy_r;
  assign failed_eff  = failed_r && !in_ch.start_req;

  always_comb begin
    len_sat = (in_ch.code_length > LW'(W)) ? LW'(W) : in_ch.code_length;
    shamt   = LW'(W) - len_sat;
  end

  always_comb begin
    tok_c[0].valid  = in_acc;
    tok_c[0].status = failed_eff ? ST_FAILED : ST_OK;
    tok_c[0].stored = 1'b0;
    tok_c[0].last   = in_ch.last_code;
    word_c[0]       = in_ch.code_bits << shamt;
    len_c[0]        = len_sat;
    rem_c[0]        = in_ch.start_req ? '0 : count_r;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    pcc_cell #(.W(W), .LW(LW), .CW(CW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tok_i  (tok_c[i]),
      .word_i (word_c[i]),
      .len_i  (len_c[i]),
      .rem_i  (rem_c[i]),
      .tok_o  (tok_c[i+1]),
      .word_o (word_c[i+1]),
      .len_o  (len_c[i+1]),
      .rem_o  (rem_c[i+1])
    );
  end

  for (genvar i = 0; i <= N; i++) begin : g_vld
    assign tok_valid_vec[i] = tok_c[i].valid;
  end

  // A word that cleared every stored word but found no empty cell overflowed.
  assign end_status = (tok_c[N].status == ST_OK && !tok_c[N].stored) ? ST_FULL
                                                                     : tok_c[N].status;
  assign out_free   = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      failed_r     <= 1'b0;
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_r <= 1'b1;
        if (in_ch.start_req) begin
          count_r  <= '0;
          failed_r <= 1'b0;
        end
      end
      if (tok_c[N].valid) begin
        if (end_status == ST_OK) begin
          count_r <= count_r + 1'b1;
        end else begin
          failed_r <= 1'b1;
        end
      end
      if (pend_valid_r && out_free) begin
        out_valid_r  <= 1'b1;
        pend_valid_r <= 1'b0;
        busy_r       <= 1'b0;
      end else if (tok_c[N].valid) begin
        if (out_free) begin
          out_valid_r <= 1'b1;
          busy_r      <= 1'b0;
        end else begin
          pend_valid_r <= 1'b1;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid_r && out_free) begin
      out_status_r <= pend_status_r;
      out_done_r   <= pend_done_r;
    end else if (tok_c[N].valid) begin
      if (out_free) begin
        out_status_r <= end_status;
        out_done_r   <= tok_c[N].last;
      end else begin
        pend_status_r <= end_status;
        pend_done_r   <= tok_c[N].last;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.still_valid = (out_status_r == ST_OK);
  assign out_ch.set_done    = out_done_r;

`ifndef SYNTHESIS
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_valid_vec))
    else $error("more than one word in the cell chain");

  a_fail_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    tok_c[N].valid && (end_status != ST_OK) |=> failed_r)
    else $error("failing word did not mark the set failed");

  a_pend_held: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r && busy_r)
    else $error("held result without a waiting output");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_CODES))
    else $error("stored word count beyond capacity");
`endif

endmodule
